// File: design/msa_pkg.sv
`default_nettype none

package msa_pkg;

   // element width
   localparam int unsigned VALUE_W = 32;

   // program steps of the sort sequencer
   typedef enum logic [3:0] {
      STEP_LOAD,
      STEP_SORT,
      STEP_PASS_CHECK,
      STEP_RUN,
      STEP_HEAD_L,
      STEP_HEAD_R,
      STEP_MERGE,
      STEP_FILL,
      STEP_RUN_NEXT,
      STEP_PASS_NEXT,
      STEP_EMIT_READ,
      STEP_EMIT_WRITE,
      STEP_EMIT_CHECK,
      STEP_DONE
   } step_type;

   // datapath operation of one control word
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SORT_INIT,
      OP_RUN_INIT,
      OP_HEAD_L,
      OP_HEAD_R,
      OP_MERGE,
      OP_FILL,
      OP_RUN_NEXT,
      OP_PASS_NEXT,
      OP_EMIT_READ,
      OP_EMIT_WRITE,
      OP_DONE
   } op_type;

   // branch condition of one control word
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_LAST_IN,
      COND_W_LT_N,
      COND_RUN_END,
      COND_REND_GE_N,
      COND_OUT_FREE,
      COND_LO_LT_N
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump_true;
      step_type jump_false;
   } ctrl_type;

   // control store: one word per step
   function automatic ctrl_type ctrl_rom(input step_type step);
      ctrl_type word;
      case (step)
         STEP_LOAD:       word = '{OP_LOAD,       COND_LAST_IN,   STEP_SORT,       STEP_LOAD};
         STEP_SORT:       word = '{OP_SORT_INIT,  COND_ALWAYS,    STEP_PASS_CHECK, STEP_PASS_CHECK};
         STEP_PASS_CHECK: word = '{OP_NONE,       COND_W_LT_N,    STEP_RUN,        STEP_EMIT_READ};
         STEP_RUN:        word = '{OP_RUN_INIT,   COND_ALWAYS,    STEP_HEAD_L,     STEP_HEAD_L};
         STEP_HEAD_L:     word = '{OP_HEAD_L,     COND_ALWAYS,    STEP_HEAD_R,     STEP_HEAD_R};
         STEP_HEAD_R:     word = '{OP_HEAD_R,     COND_ALWAYS,    STEP_MERGE,      STEP_MERGE};
         STEP_MERGE:      word = '{OP_MERGE,      COND_RUN_END,   STEP_RUN_NEXT,   STEP_FILL};
         STEP_FILL:       word = '{OP_FILL,       COND_ALWAYS,    STEP_MERGE,      STEP_MERGE};
         STEP_RUN_NEXT:   word = '{OP_RUN_NEXT,   COND_REND_GE_N, STEP_PASS_NEXT,  STEP_RUN};
         STEP_PASS_NEXT:  word = '{OP_PASS_NEXT,  COND_ALWAYS,    STEP_PASS_CHECK, STEP_PASS_CHECK};
         STEP_EMIT_READ:  word = '{OP_EMIT_READ,  COND_ALWAYS,    STEP_EMIT_WRITE, STEP_EMIT_WRITE};
         STEP_EMIT_WRITE: word = '{OP_EMIT_WRITE, COND_OUT_FREE,  STEP_EMIT_CHECK, STEP_EMIT_WRITE};
         STEP_EMIT_CHECK: word = '{OP_NONE,       COND_LO_LT_N,   STEP_EMIT_READ,  STEP_DONE};
         STEP_DONE:       word = '{OP_DONE,       COND_ALWAYS,    STEP_LOAD,       STEP_LOAD};
         default:         word = '{OP_NONE,       COND_ALWAYS,    STEP_LOAD,       STEP_LOAD};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

// File: design/msa_ram.sv
`default_nettype none

module msa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/merge_sort_ascending.sv
// merge_sort_ascending: sorts a set of signed 32-bit values into ascending order.
// The req channel takes one element per item; req_item_last closes the set.
// Up to DEPTH elements are kept; later elements of the same set are dropped and
// rsp_overflow is then high on every result of that set.
// Loading takes one item per cycle. After the last item the block sorts bottom-up,
// merging runs of width 1, 2, 4 and so on between two single-port-read RAMs, under a
// microcoded step sequencer. Each merged element is a write plus a head refill from
// the RAM's registered read, with no refill after the last of a run; each run adds
// a setup step, two head reads and a closing step, and each of the ceil(log2 n)
// passes adds a pass check and a pass step, with a start step and a final check.
// The rsp channel then gives the n sorted elements, rsp_sorted_last on the final
// one; each element takes a read, a write step that waits while rsp_stall holds the
// output register, and a check step, and a done step closes the set.
// req_stall is high from the last item until the set is emitted. An output
// register holds a stalled result; the next set may load while it waits.
// Synchronous active-high reset empties the element count, clears the overflow
// flag and the output valid, and leaves the block ready for a new set.
`default_nettype none

module merge_sort_ascending import msa_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [VALUE_W-1:0] req_item_value,
   input  wire logic                      req_item_last,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [VALUE_W-1:0]      rsp_sorted_value,
   output logic                           rsp_sorted_last,
   output logic                           rsp_overflow
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 2;

   // sequencer
   step_type step_ff, step_in;
   ctrl_type ctrl;
   logic     cond_met;

   // datapath registers
   logic [CW-1:0]              count_ff, count_in;
   logic                       dropped_ff, dropped_in;
   logic [CW:0]                w_ff, w_in;
   logic [CW-1:0]              lo_ff, lo_in;
   logic [CW-1:0]              l_ff, l_in;
   logic [CW-1:0]              r_ff, r_in;
   logic [CW-1:0]              o_ff, o_in;
   logic [CW-1:0]              l_end_ff, l_end_in;
   logic [CW-1:0]              r_end_ff, r_end_in;
   logic signed [VALUE_W-1:0]  head_l_ff, head_l_in;
   logic signed [VALUE_W-1:0]  head_r_ff, head_r_in;
   logic                       took_left_ff, took_left_in;
   logic                       src_ff, src_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_overflow_ff, rsp_overflow_in;

   // memory ports
   logic               wr_a_en, wr_b_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [CW-1:0]      rd_index;
   logic [VALUE_W-1:0] rd_data_a, rd_data_b;
   logic signed [VALUE_W-1:0] src_data;

   // helpers
   logic          req_accept;
   logic          out_free;
   logic          take_left;
   logic          run_end;
   logic [CW-1:0] l_inc, r_inc, o_inc, lo_inc;
   logic [SW-1:0] sum_lw, sum_lww, n_ext;
   logic [CW-1:0] lw_min, lww_min;

   msa_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_index[AW-1:0]),
      .rd_data (rd_data_a)
   );

   msa_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_index[AW-1:0]),
      .rd_data (rd_data_b)
   );

   // control word and handshake
   always_comb begin
      ctrl       = ctrl_rom(step_ff);
      req_stall  = (ctrl.op != OP_LOAD);
      req_accept = req_valid && !req_stall;
      out_free   = !rsp_valid_ff || !rsp_stall;
      src_data   = src_ff ? $signed(rd_data_b) : $signed(rd_data_a);
   end

   // run bounds and merge choice
   always_comb begin
      l_inc   = l_ff + CW'(1);
      r_inc   = r_ff + CW'(1);
      o_inc   = o_ff + CW'(1);
      lo_inc  = lo_ff + CW'(1);
      n_ext   = SW'(count_ff);
      sum_lw  = SW'(lo_ff) + SW'(w_ff);
      sum_lww = sum_lw + SW'(w_ff);
      lw_min  = (sum_lw < n_ext) ? sum_lw[CW-1:0] : count_ff;
      lww_min = (sum_lww < n_ext) ? sum_lww[CW-1:0] : count_ff;
      take_left = (l_ff < l_end_ff) && ((r_ff >= r_end_ff) || !(head_l_ff > head_r_ff));
      run_end   = (o_inc == r_end_ff);
   end

   // branch condition
   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:    cond_met = 1'b1;
         COND_LAST_IN:   cond_met = req_accept && req_item_last;
         COND_W_LT_N:    cond_met = (w_ff < {1'b0, count_ff});
         COND_RUN_END:   cond_met = run_end;
         COND_REND_GE_N: cond_met = (r_end_ff >= count_ff);
         COND_OUT_FREE:  cond_met = out_free;
         COND_LO_LT_N:   cond_met = (lo_ff < count_ff);
         default:        cond_met = 1'b1;
      endcase
      step_in = cond_met ? ctrl.jump_true : ctrl.jump_false;
   end

   // datapath operations
   always_comb begin
      count_in        = count_ff;
      dropped_in      = dropped_ff;
      w_in            = w_ff;
      lo_in           = lo_ff;
      l_in            = l_ff;
      r_in            = r_ff;
      o_in            = o_ff;
      l_end_in        = l_end_ff;
      r_end_in        = r_end_ff;
      head_l_in       = head_l_ff;
      head_r_in       = head_r_ff;
      took_left_in    = took_left_ff;
      src_in          = src_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_overflow_in = rsp_overflow_ff;
      wr_a_en         = 1'b0;
      wr_b_en         = 1'b0;
      wr_addr         = o_ff[AW-1:0];
      wr_data         = take_left ? head_l_ff : head_r_ff;
      rd_index        = lo_ff;

      case (ctrl.op)
         // store an element or note the drop
         OP_LOAD: begin
            wr_addr = count_ff[AW-1:0];
            wr_data = req_item_value;
            if (req_accept) begin
               if (count_ff < CW'(DEPTH)) begin
                  wr_a_en  = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         OP_SORT_INIT: begin
            w_in   = (CW + 1)'(1);
            lo_in  = '0;
            src_in = 1'b0;
         end
         // set up left and right run, fetch left head
         OP_RUN_INIT: begin
            l_in     = lo_ff;
            o_in     = lo_ff;
            l_end_in = lw_min;
            r_in     = lw_min;
            r_end_in = lww_min;
            rd_index = lo_ff;
         end
         OP_HEAD_L: begin
            head_l_in = src_data;
            rd_index  = r_ff;
         end
         OP_HEAD_R: begin
            head_r_in = src_data;
         end
         // move the smaller head to the other store, fetch its successor
         OP_MERGE: begin
            wr_a_en      = src_ff;
            wr_b_en      = !src_ff;
            o_in         = o_inc;
            took_left_in = take_left;
            if (take_left) begin
               l_in     = l_inc;
               rd_index = l_inc;
            end else begin
               r_in     = r_inc;
               rd_index = r_inc;
            end
         end
         OP_FILL: begin
            if (took_left_ff) begin
               head_l_in = src_data;
            end else begin
               head_r_in = src_data;
            end
         end
         OP_RUN_NEXT: begin
            lo_in = r_end_ff;
         end
         OP_PASS_NEXT: begin
            w_in   = w_ff << 1;
            src_in = !src_ff;
            lo_in  = '0;
         end
         OP_EMIT_READ: begin
            rd_index = lo_ff;
         end
         // hand one sorted element to the output register
         OP_EMIT_WRITE: begin
            rd_index = lo_ff;
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = src_data;
               rsp_last_in     = (lo_inc == count_ff);
               rsp_overflow_in = dropped_ff;
               lo_in           = lo_inc;
            end
         end
         OP_DONE: begin
            count_in   = '0;
            dropped_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff            <= w_in;
      lo_ff           <= lo_in;
      l_ff            <= l_in;
      r_ff            <= r_in;
      o_ff            <= o_in;
      l_end_ff        <= l_end_in;
      r_end_ff        <= r_end_in;
      head_l_ff       <= head_l_in;
      head_r_ff       <= head_r_in;
      took_left_ff    <= took_left_in;
      src_ff          <= src_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_sorted_last  = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

`default_nettype wire

// File: tb/sv/merge_sort_ascending_tb.sv
module merge_sort_ascending_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msa_pkg::*;

   localparam int DEPTH = 32;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT = 10;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   // value generation styles for random sets
   typedef enum int {
      FILL_ANY,
      FILL_NARROW,
      FILL_RISING,
      FILL_FALLING,
      FILL_EXTREME
   } fill_style_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      overflow;
   } sorted_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic req_item_last = 1'b0;
   logic rsp_stall = 1'b0;
   wire  req_stall;
   wire  rsp_valid;
   wire  signed [VALUE_W-1:0] rsp_sorted_value;
   wire  rsp_sorted_last;
   wire  rsp_overflow;

   // own copy of the set being collected, kept in ascending order
   logic signed [VALUE_W-1:0] kept_sorted [DEPTH];
   int unsigned kept_count = 0;
   logic set_dropped = 1'b0;
   sorted_entry_type pending_sorted [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic start_hold = 1'b0;
   int hold_left = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   merge_sort_ascending #(.DEPTH(DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item_value   (req_item_value),
      .req_item_last    (req_item_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_sorted_last  (rsp_sorted_last),
      .rsp_overflow     (rsp_overflow)
   );

   always #5 clock = ~clock;

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endtask

   // insert a kept element in order; on the last item queue the whole sorted set
   task automatic collect_element(input logic signed [VALUE_W-1:0] elem_value,
                                  input logic elem_last);
      int pos;
      sorted_entry_type entry;
      if (kept_count < DEPTH) begin
         pos = kept_count;
         while (pos > 0 && kept_sorted[pos-1] > elem_value) begin
            kept_sorted[pos] = kept_sorted[pos-1];
            pos--;
         end
         kept_sorted[pos] = elem_value;
         kept_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (elem_last) begin
         for (int k = 0; k < kept_count; k++) begin
            entry.value = kept_sorted[k];
            entry.last = (k == kept_count - 1);
            entry.overflow = set_dropped;
            pending_sorted.push_back(entry);
         end
         kept_count = 0;
         set_dropped = 1'b0;
      end
   endtask

   // offer one item, hold it until accepted, then predict
   task automatic send_item(input logic signed [VALUE_W-1:0] elem_value,
                            input logic elem_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item_value <= elem_value;
      req_item_last <= elem_last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      collect_element(elem_value, elem_last);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(input fill_style_type style,
                                                           input int idx,
                                                           input int base);
      logic signed [VALUE_W-1:0] v;
      case (style)
         FILL_NARROW:  v = $signed($urandom_range(8)) - 4;
         FILL_RISING:  v = base + idx * $signed($urandom_range(100));
         FILL_FALLING: v = base - idx * $signed($urandom_range(100));
         FILL_EXTREME: begin
            case ($urandom_range(6))
               0: v = VALUE_MIN;
               1: v = VALUE_MIN + 1;
               2: v = -1;
               3: v = 0;
               4: v = 1;
               5: v = VALUE_MAX - 1;
               default: v = VALUE_MAX;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_random_set(input int set_size);
      fill_style_type style;
      int base;
      style = fill_style_type'($urandom_range(4));
      base = $signed($urandom_range(20000)) - 10000;
      for (int k = 0; k < set_size; k++) begin
         send_item(pick_value(style, k, base), k == set_size - 1);
      end
   endtask

   // single elements, short sets, presorted runs, reversed runs, ties, extremes
   task automatic test_small_sets();
      send_item(0, 1'b1);
      send_item(VALUE_MAX, 1'b1);
      send_item(VALUE_MAX, 1'b0);
      send_item(VALUE_MIN, 1'b1);
      send_item(-2, 1'b0);
      send_item(-1, 1'b0);
      send_item(0, 1'b0);
      send_item(1, 1'b1);
      send_item(100, 1'b0);
      send_item(50, 1'b0);
      send_item(0, 1'b0);
      send_item(-50, 1'b0);
      send_item(-100, 1'b1);
      send_item(7, 1'b0);
      send_item(7, 1'b0);
      send_item(-1, 1'b0);
      send_item(7, 1'b1);
      send_item(VALUE_MIN, 1'b0);
      send_item(-1, 1'b0);
      send_item(VALUE_MAX, 1'b0);
      send_item(0, 1'b1);
   endtask

   // exactly full, then several dropped including the last item
   task automatic test_buffer_full();
      for (int k = 0; k < DEPTH; k++) begin
         send_item(VALUE_MAX - k, k == DEPTH - 1);
      end
      for (int k = 0; k < DEPTH + 3; k++) begin
         send_item(VALUE_MIN + k * 3, k == DEPTH + 2);
      end
   endtask

   // random sets, mostly small, some full and some overflowing
   task automatic test_random_sets(input int item_target);
      int sent;
      int pick;
      int set_size;
      sent = 0;
      while (sent < item_target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            set_size = $urandom_range(8, 1);
         end else if (pick < 90) begin
            set_size = $urandom_range(DEPTH - 1, 9);
         end else if (pick < 96) begin
            set_size = DEPTH;
         end else begin
            set_size = $urandom_range(DEPTH + 8, DEPTH + 1);
         end
         send_random_set(set_size);
         sent += set_size;
      end
   endtask

   // receiver holds off while two sets are offered, so the block backs up
   task automatic test_backpressure();
      req_valid <= 1'b0;
      while (pending_sorted.size() != 0) begin
         @(posedge clock);
      end
      start_hold <= 1'b1;
      @(posedge clock);
      start_hold <= 1'b0;
      send_random_set(6);
      send_random_set(5);
   endtask

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (start_hold) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin
      sorted_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sorted.size() == 0) begin
            note_failure($sformatf("unexpected result: value %0d last %0b overflow %0b",
                                   rsp_sorted_value, rsp_sorted_last, rsp_overflow));
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_sorted_value !== want.value || rsp_sorted_last !== want.last ||
                rsp_overflow !== want.overflow) begin
               note_failure($sformatf({"mismatch: expected value %0d last %0b overflow %0b,",
                                       " got value %0d last %0b overflow %0b"},
                                      want.value, want.last, want.overflow,
                                      rsp_sorted_value, rsp_sorted_last, rsp_overflow));
            end
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_stall_pct = 67;
      test_small_sets();
      test_buffer_full();
      test_random_sets(8);

      send_idle_pct = 67;
      recv_stall_pct = 8;
      test_random_sets(8);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();
      test_random_sets(8);

      req_valid <= 1'b0;
      while (pending_sorted.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
